// ===== rtl/ghc_pkg.sv =====
package ghc_pkg;

    // Table geometry
    localparam int MAX_CLUSTERS = 64;
    localparam int MAX_LEN      = 256;
    localparam int CL_W         = $clog2(MAX_CLUSTERS);
    localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1);
    localparam int ADDR_W       = $clog2(MAX_LEN);

    // Field and counter widths
    localparam int CH_W  = 8;
    localparam int MIS_W = 9;
    localparam int POS_W = 9;
    localparam int NUM_W = 16;

    localparam logic [MIS_W-1:0] MIS_SAT    = '1;
    localparam logic [POS_W-1:0] POS_SAT    = '1;
    localparam logic [NUM_W-1:0] NUM_SAT    = '1;
    localparam logic [MIS_W-1:0] EMPTY_DIST = MIS_W'(256);

    // Configuration register indexes
    localparam logic REG_MAX_DIST = 1'b0;
    localparam logic REG_READ_LEN = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SCAN,
        S_DONE
    } t_state;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              clear;
        logic              shift;
        logic              cmp;
        logic              wr;
        logic [CNT_W-1:0]  count;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic [CH_W-1:0]   ch;
    } t_cell_ctl;

endpackage

// ===== rtl/ghc_ram.sv =====
module ghc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ghc_cell.sv =====
module ghc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ghc_pkg::t_cell_ctl         i_ctl,
    input  logic [ghc_pkg::CL_W-1:0]   i_idx,
    input  logic [ghc_pkg::MIS_W-1:0]  i_cnt_next,
    output logic [ghc_pkg::MIS_W-1:0]  o_cnt
);
    import ghc_pkg::*;

    logic [CH_W-1:0]  w_rdata;
    logic             w_active;
    logic             w_owner;
    logic [MIS_W-1:0] r_cnt;
    logic [MIS_W-1:0] n_cnt;

    // A cell holds one centroid; the next free cell captures the read in progress.
    assign w_active = CNT_W'(i_idx) < i_ctl.count;
    assign w_owner  = CNT_W'(i_idx) == i_ctl.count;

    ghc_ram #(
        .WIDTH (CH_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr && w_owner),
        .i_waddr (i_ctl.wr_addr),
        .i_wdata (i_ctl.ch),
        .i_raddr (i_ctl.rd_addr),
        .o_rdata (w_rdata)
    );

    // Mismatch count: cleared per read, bumped on each differing character,
    // and shifted toward the head of the chain during the minimum scan.
    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.clear) begin
            n_cnt = '0;
        end else if (i_ctl.shift) begin
            n_cnt = i_cnt_next;
        end else if (i_ctl.cmp && w_active && (w_rdata != i_ctl.ch) && (r_cnt != MIS_SAT)) begin
            n_cnt = r_cnt + MIS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;

endmodule

// ===== rtl/greedy_hamming_clustering.sv =====
// Each request is accepted in S_IDLE, which addresses the centroid stores, and is
// compared in S_CMP. A final character of a read of the right length adds a scan of
// the mismatch counts, which shift one cell per cycle toward the head of the chain;
// S_DONE then forms the result and waits until the output register is free.
// Synchronous active-low reset empties the table, zeroes the read counter and
// restores a join limit of 2 and a read length of 100; centroid memory is not cleared.
module greedy_hamming_clustering (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_base_char,
    input  logic                       i_read_end,
    input  logic                       i_batch_start,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [15:0]                o_read_number,
    output logic [5:0]                 o_cluster_number,
    output logic                       o_founded_new,
    output logic [8:0]                 o_nearest_distance,
    output logic                       o_table_full,
    output logic                       o_length_error,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [8:0]                 i_cfg_data
);
    import ghc_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [POS_W-1:0]  r_pos;
    logic [NUM_W-1:0]  r_rdcnt;
    logic [MIS_W-1:0]  r_maxd;
    logic [POS_W-1:0]  r_rl;
    logic [CH_W-1:0]   r_ch;
    logic [ADDR_W-1:0] r_addr;
    logic              r_cmp_en;
    logic              r_last;
    logic              r_lenok;
    logic [NUM_W-1:0]  r_num;
    logic [CNT_W-1:0]  r_k;
    logic              r_have;
    logic [MIS_W-1:0]  r_best_d;
    logic [CL_W-1:0]   r_best_i;

    logic              r_ovalid;
    logic [NUM_W-1:0]  r_onum;
    logic [5:0]        r_ocl;
    logic              r_ofound;
    logic [MIS_W-1:0]  r_odist;
    logic              r_ofull;
    logic              r_olerr;

    logic              w_accept;
    logic              w_load;
    logic              w_rl_wr;
    logic [POS_W-1:0]  w_p;
    logic [POS_W-1:0]  w_p1;
    logic              w_join;
    logic              w_found;
    logic [MIS_W-1:0]  w_head;
    t_cell_ctl         w_ctl;
    logic [MIS_W-1:0]  w_chain [MAX_CLUSTERS+1];

    assign w_accept = i_valid && !o_stall;
    assign w_load   = (r_state == S_DONE) && (!r_ovalid || !i_stall);
    assign w_rl_wr  = i_cfg_we && (i_cfg_idx == REG_READ_LEN);
    assign o_stall  = r_state != S_IDLE;

    // Position of the incoming character; a batch start restarts the read.
    assign w_p  = i_batch_start ? '0 : r_pos;
    assign w_p1 = (w_p == POS_SAT) ? w_p : w_p + POS_W'(1);

    // Cluster decision once the scan has found the nearest centroid.
    assign w_join  = r_have && (r_best_d <= r_maxd);
    assign w_found = r_lenok && !w_join && (int'(r_count) < MAX_CLUSTERS);

    // Control broadcast along the cell chain
    always_comb begin
        w_ctl.clear   = (w_accept && i_batch_start) || w_load || w_rl_wr;
        w_ctl.shift   = (r_state == S_SCAN) && (r_k != r_count);
        w_ctl.cmp     = (r_state == S_CMP) && r_cmp_en;
        w_ctl.wr      = (r_state == S_CMP) && r_cmp_en;
        w_ctl.count   = r_count;
        w_ctl.rd_addr = ADDR_W'(w_p);
        w_ctl.wr_addr = r_addr;
        w_ctl.ch      = r_ch;
    end

    // Row of centroid cells; counts move one cell toward the head while scanning.
    assign w_chain[MAX_CLUSTERS] = '0;
    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
        ghc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_idx      (CL_W'(g)),
            .i_cnt_next (w_chain[g+1]),
            .o_cnt      (w_chain[g])
        );
    end
    assign w_head = w_chain[0];

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CMP;
            end
            S_CMP: begin
                if (!r_last) n_state = S_IDLE;
                else if (!r_lenok) n_state = S_DONE;
                else n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_k == r_count) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Read tracking, table fill and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos   <= '0;
            r_rdcnt <= '0;
            r_maxd  <= MIS_W'(2);
            r_rl    <= POS_W'(100);
        end else begin
            if (i_cfg_we && (i_cfg_idx == REG_MAX_DIST)) begin
                r_maxd <= i_cfg_data;
            end
            if (w_rl_wr) begin
                r_rl    <= i_cfg_data;
                r_count <= '0;
                r_pos   <= '0;
            end else if (w_accept) begin
                r_pos <= i_read_end ? '0 : w_p1;
                if (i_batch_start) begin
                    r_count <= '0;
                end
                if (i_read_end) begin
                    if (i_batch_start) r_rdcnt <= NUM_W'(1);
                    else if (r_rdcnt != NUM_SAT) r_rdcnt <= r_rdcnt + NUM_W'(1);
                end else if (i_batch_start) begin
                    r_rdcnt <= '0;
                end
            end else if (w_load && w_found) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Per-character request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch     <= i_base_char;
            r_addr   <= ADDR_W'(w_p);
            r_cmp_en <= (w_p < r_rl) && (int'(w_p) < MAX_LEN);
            r_last   <= i_read_end;
            r_lenok  <= (r_rl != '0) && (int'(r_rl) <= MAX_LEN) && (r_rl != POS_SAT)
                        && (w_p1 == r_rl);
            r_num    <= i_batch_start ? '0 : r_rdcnt;
        end
    end

    // Serial minimum over the counts arriving at the head; ties keep the lower index.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP) begin
            r_k      <= '0;
            r_have   <= 1'b0;
            r_best_d <= EMPTY_DIST;
            r_best_i <= '0;
        end else if (w_ctl.shift) begin
            r_k <= r_k + CNT_W'(1);
            if (!r_have || (w_head < r_best_d)) begin
                r_have   <= 1'b1;
                r_best_d <= w_head;
                r_best_i <= CL_W'(r_k);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_onum   <= r_num;
            r_olerr  <= !r_lenok;
            r_ofound <= w_found;
            r_ofull  <= r_lenok && !w_join && !w_found;
            r_odist  <= r_lenok ? r_best_d : '0;
            if (!r_lenok) r_ocl <= '0;
            else if (w_join) r_ocl <= 6'(r_best_i);
            else if (w_found) r_ocl <= 6'(r_count);
            else r_ocl <= '0;
        end
    end

    assign o_valid            = r_ovalid;
    assign o_read_number      = r_onum;
    assign o_cluster_number   = r_ocl;
    assign o_founded_new      = r_ofound;
    assign o_nearest_distance = r_odist;
    assign o_table_full       = r_ofull;
    assign o_length_error     = r_olerr;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_CLUSTERS)
        else $error("cluster count beyond table size");

    a_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_founded_new && (o_table_full || o_length_error)))
        else $error("founded cluster together with an error flag");

    a_lerr_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_length_error) |-> (o_cluster_number == '0 && o_nearest_distance == '0))
        else $error("length error result carries cluster fields");

    a_found_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_found && !w_rl_wr) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("new cluster did not advance the count");
`endif

endmodule

// ===== bench/greedy_hamming_clustering_tb.sv =====
module greedy_hamming_clustering_tb;
    import ghc_pkg::*;

    typedef struct {
        logic [15:0] read_number;
        logic [5:0]  cluster_number;
        logic        founded_new;
        logic [8:0]  nearest_distance;
        logic        table_full;
        logic        length_error;
    } t_cluster_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_base_char = '0;
    logic        i_read_end = 1'b0;
    logic        i_batch_start = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_read_number;
    logic [5:0]  o_cluster_number;
    logic        o_founded_new;
    logic [8:0]  o_nearest_distance;
    logic        o_table_full;
    logic        o_length_error;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [8:0]  i_cfg_data = '0;

    greedy_hamming_clustering i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the clustering state.
    logic [7:0] centroid_chars [MAX_CLUSTERS][MAX_LEN];
    int         clusters_used;
    int         miss_tally [MAX_CLUSTERS];
    int         char_idx;
    int         read_idx;
    int         cfg_max_dist;
    int         cfg_read_len;

    t_cluster_result pending_results [$];
    int  errors;
    bit  quiet;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  items_sent;

    function automatic void clear_read_state();
        char_idx = 0;
        foreach (miss_tally[c]) miss_tally[c] = 0;
    endfunction

    // Apply one accepted request and queue the result it causes, if any.
    function automatic void track_character(logic [7:0] ch, logic last, logic start);
        t_cluster_result r;
        int best;
        bit have;
        bit len_ok;
        if (start) begin
            clusters_used = 0;
            clear_read_state();
            read_idx = 0;
        end
        if (char_idx < cfg_read_len && char_idx < MAX_LEN) begin
            for (int c = 0; c < clusters_used; c++) begin
                if (centroid_chars[c][char_idx] != ch && miss_tally[c] < 511)
                    miss_tally[c]++;
            end
            if (clusters_used < MAX_CLUSTERS)
                centroid_chars[clusters_used][char_idx] = ch;
        end
        if (char_idx < 511)
            char_idx++;
        if (!last)
            return;
        r.read_number = read_idx[15:0];
        if (read_idx < 16'hFFFF)
            read_idx++;
        r.cluster_number = '0;
        r.founded_new = 1'b0;
        r.nearest_distance = '0;
        r.table_full = 1'b0;
        r.length_error = 1'b0;
        len_ok = cfg_read_len >= 1 && cfg_read_len <= MAX_LEN && char_idx == cfg_read_len;
        if (!len_ok) begin
            r.length_error = 1'b1;
        end else begin
            int near_d;
            near_d = 256;
            best = 0;
            have = 0;
            for (int c = 0; c < clusters_used; c++) begin
                if (!have || miss_tally[c] < near_d) begin
                    near_d = miss_tally[c];
                    best = c;
                    have = 1;
                end
            end
            r.nearest_distance = near_d[8:0];
            if (have && near_d <= cfg_max_dist) begin
                r.cluster_number = best[5:0];
            end else if (clusters_used < MAX_CLUSTERS) begin
                r.cluster_number = clusters_used[5:0];
                r.founded_new = 1'b1;
                clusters_used++;
            end else begin
                r.table_full = 1'b1;
            end
        end
        clear_read_state();
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Receiver side: stall in random bursts.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(99) < recv_idle_pct) begin
            stall_left <= $urandom_range(9);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_cluster_result w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result, read_number %0d", o_read_number);
                errors++;
            end else begin
                w = pending_results.pop_front();
                check_field("read_number", w.read_number, o_read_number);
                check_field("cluster_number", w.cluster_number, o_cluster_number);
                check_field("founded_new", w.founded_new, o_founded_new);
                check_field("nearest_distance", w.nearest_distance, o_nearest_distance);
                check_field("table_full", w.table_full, o_table_full);
                check_field("length_error", w.length_error, o_length_error);
            end
        end
    end

    // Send one request, with an optional idle burst in front of it.
    task automatic send_char(logic [7:0] ch, logic last, logic start);
        if (!quiet && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(10, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_base_char <= ch;
        i_read_end <= last;
        i_batch_start <= start;
        do @(posedge i_clk); while (o_stall);
        track_character(ch, last, start);
        items_sent++;
    endtask

    task automatic send_read(logic [7:0] data [MAX_LEN], int len, bit start);
        for (int k = 0; k < len; k++)
            send_char(data[k], k == len - 1, start && k == 0);
    endtask

    // Hold the sender until every expected result has come and the block is idle.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[8:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MAX_DIST) begin
            cfg_max_dist = value & 9'h1FF;
        end else begin
            cfg_read_len = value & 9'h1FF;
            clusters_used = 0;
            clear_read_state();
        end
    endtask

    function automatic void fill_const(ref logic [7:0] data [MAX_LEN], input logic [7:0] v);
        foreach (data[k]) data[k] = v;
    endfunction

    // A short read under the reset settings is a length error.
    task automatic test_reset_defaults();
        logic [7:0] d [MAX_LEN];
        fill_const(d, 8'h41);
        send_read(d, 3, 1'b0);
    endtask

    // Joins, new clusters, ties, wrong lengths and a batch start mid-read.
    task automatic test_directed_reads();
        logic [7:0] d [MAX_LEN];
        write_reg(REG_READ_LEN, 4);
        write_reg(REG_MAX_DIST, 1);
        fill_const(d, 8'h00);
        send_read(d, 4, 1'b1);
        fill_const(d, 8'hFF);
        send_read(d, 4, 1'b0);
        d[0] = 8'h00; d[1] = 8'h00; d[2] = 8'h00;
        send_read(d, 4, 1'b0);
        // Equal distance to two centroids, both beyond the join limit: a new cluster is founded.
        d[2] = 8'hFF;
        send_read(d, 4, 1'b0);
        send_read(d, 6, 1'b0);
        send_read(d, 2, 1'b0);
        // A batch start in the middle of a read drops the partial read.
        send_char(8'h5A, 1'b0, 1'b0);
        send_char(8'hA5, 1'b0, 1'b0);
        send_read(d, 4, 1'b1);
        i_valid <= 1'b0;
    endtask

    // One-character reads with exact matching fill the table past its size.
    task automatic test_table_full();
        write_reg(REG_READ_LEN, 1);
        write_reg(REG_MAX_DIST, 0);
        for (int k = 0; k < MAX_CLUSTERS + 3; k++)
            send_char(k[7:0], 1'b1, k == 0);
        send_char(8'h07, 1'b1, 1'b0);
        i_valid <= 1'b0;
    endtask

    // Longest reads, widest distance, and read_length values that are invalid.
    task automatic test_length_extremes();
        logic [7:0] d [MAX_LEN];
        write_reg(REG_READ_LEN, MAX_LEN);
        write_reg(REG_MAX_DIST, 256);
        foreach (d[k]) d[k] = $urandom;
        send_read(d, MAX_LEN, 1'b1);
        d[10] = ~d[10];
        send_read(d, MAX_LEN, 1'b0);
        foreach (d[k]) d[k] = ~d[k];
        send_read(d, MAX_LEN, 1'b0);
        write_reg(REG_READ_LEN, 0);
        send_read(d, 1, 1'b0);
        write_reg(REG_READ_LEN, 300);
        send_read(d, 3, 1'b0);
        write_reg(REG_READ_LEN, 511);
        send_read(d, 2, 1'b0);
        i_valid <= 1'b0;
    endtask

    // Mostly well-formed reads mutated from a few prototypes, plus broken ones.
    task automatic test_random_reads();
        int lens [6] = '{8, 16, 5, 12, 1, 3};
        int dists [6] = '{2, 0, 256, 3, 0, 1};
        logic [7:0] protos [4][MAX_LEN];
        logic [7:0] d [MAX_LEN];
        int target;
        int len;
        int pick;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_READ_LEN, lens[ph]);
            write_reg(REG_MAX_DIST, dists[ph]);
            quiet = (ph == 5);
            send_idle_pct = $urandom_range(30);
            recv_idle_pct = $urandom_range(30);
            foreach (protos[p, k]) protos[p][k] = $urandom;
            target = items_sent + 130;
            while (items_sent < target) begin
                pick = $urandom_range(99);
                d = protos[$urandom_range(3)];
                for (int m = $urandom_range(cfg_max_dist > 4 ? 6 : cfg_max_dist + 2); m > 0; m--)
                    d[$urandom_range(lens[ph] - 1)] = $urandom;
                if (lens[ph] == 1 && $urandom_range(1)) d[0] = $urandom;
                len = lens[ph];
                if (pick < 8) begin
                    len = lens[ph] + $urandom_range(3, 1);
                end else if (pick < 14 && lens[ph] > 1) begin
                    len = $urandom_range(lens[ph] - 1, 1);
                end else if (pick < 18) begin
                    // Partial read cut short by a new batch.
                    send_char($urandom, 1'b0, 1'b0);
                    send_read(d, len, 1'b1);
                    continue;
                end else if (pick == 18) begin
                    drain();
                end
                send_read(d, len, $urandom_range(99) < 3);
            end
            i_valid <= 1'b0;
        end
    endtask

    initial begin
        errors = 0;
        items_sent = 0;
        quiet = 0;
        send_idle_pct = 15;
        recv_idle_pct = 15;
        clusters_used = 0;
        read_idx = 0;
        cfg_max_dist = 2;
        cfg_read_len = 100;
        clear_read_state();
        foreach (centroid_chars[c, k]) centroid_chars[c][k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_reads();
        test_table_full();
        test_length_extremes();
        test_random_reads();

        drain();
        if (errors == 0)
            $display("greedy_hamming_clustering_tb: clean");
        else
            $display("greedy_hamming_clustering_tb: errors");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #40000000;
        $display("greedy_hamming_clustering_tb: errors");
        $finish;
    end

endmodule

// ===== greedy_hamming_clustering.f =====
rtl/ghc_pkg.sv
rtl/ghc_ram.sv
rtl/ghc_cell.sv
rtl/greedy_hamming_clustering.sv
bench/greedy_hamming_clustering_tb.sv
